[rtl/apsp_pkg.sv]
package apsp_pkg;

  localparam int unsigned NodeW    = 4;
  localparam int unsigned Nodes    = 16;
  localparam int unsigned PairAW   = 2 * NodeW;
  localparam int unsigned EdgeAW   = 8;
  localparam int unsigned MaxEdges = 256;
  localparam int unsigned EcntW    = 9;
  localparam int unsigned CostW    = 16;
  localparam int unsigned AccW     = 32;
  localparam int unsigned DistW    = 21;
  localparam int unsigned CntW     = 5;

  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic signed [DistW-1:0] dist_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_LOAD,
    CMD_COMPUTE,
    CMD_READ
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NEGCYC,
    ST_FULL,
    ST_NONE
  } status_e;

  // which job the shared edge walk is doing
  typedef enum logic [1:0] {
    PH_BF,
    PH_NC,
    PH_RW
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_E_START,
    S_E_RD,
    S_E_X,
    S_E_Y,
    S_E_END,
    S_BF_VIRT,
    S_DJ_INIT,
    S_DJ_SCAN,
    S_DJ_PICK,
    S_DJ_RRD,
    S_DJ_RLX,
    S_DJ_STORE
  } state_e;

  typedef struct packed {
    logic [NodeW-1:0]        tail;
    logic [NodeW-1:0]        head;
    logic signed [CostW-1:0] cost;
  } edge_t;

  localparam acc_t DistMax = acc_t'(1048575);
  localparam acc_t DistMin = -acc_t'(1048576);

  function automatic dist_t sat_dist(acc_t v);
    dist_t r;
    if (v > DistMax) begin
      r = dist_t'(DistMax);
    end else if (v < DistMin) begin
      r = dist_t'(DistMin);
    end else begin
      r = dist_t'(v);
    end
    return r;
  endfunction

endpackage

[rtl/apsp_ram.sv]
module apsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/all_pairs_shortest_paths_unit.sv]
// channel  | direction | handshake               | payload
// in       | input     | in_valid_i / in_stall_o   | command_i from_node_i to_node_i edge_cost_i
// out      | output    | out_valid_o / out_stall_i | status_o reachable_o distance_o
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (node_count)
//
// Clear and load are answered straight from idle; a read goes through S_READ for the
// registered distance memory. Compute walks the stored edges (S_E_RD, S_E_X, S_E_Y per
// edge) for Bellman-Ford, a negative-cycle check and reweighting, then runs Dijkstra.
// Only one transaction is in flight; in_stall_o is high until its result is taken.
// Reset: node_count 16, no edges, results not computed; no clearing pass.
module all_pairs_shortest_paths_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  from_node_i,
  input  logic [3:0]  to_node_i,
  input  logic signed [15:0] edge_cost_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        reachable_o,
  output logic signed [20:0] distance_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  localparam int unsigned NW = apsp_pkg::NodeW;
  localparam int unsigned NN = apsp_pkg::Nodes;
  localparam int unsigned PW = apsp_pkg::PairAW;

  apsp_pkg::state_e  state_q, state_d;
  apsp_pkg::phase_e  phase_q, phase_d;
  apsp_pkg::status_e res_q, res_d;
  logic [apsp_pkg::CntW-1:0]  nodes_q, nodes_d;
  logic [NW-1:0]              nm1_q, nm1_d;
  logic [apsp_pkg::EcntW-1:0] ecnt_q, ecnt_d;
  logic [apsp_pkg::EdgeAW-1:0] e_q, e_d;
  logic [apsp_pkg::CntW-1:0]  pass_q, pass_d;
  logic [NW-1:0] x_q, x_d, y_q, y_d, k_q, k_d, j_q, j_d, it_q, it_d;
  logic signed [apsp_pkg::CostW-1:0] w_q, w_d;
  apsp_pkg::acc_t px_q, px_d, bx_q, bx_d, pk_q, pk_d;
  logic okx_q, okx_d, inr_q, inr_d, found_q, found_d, bok_q, bok_d;
  apsp_pkg::acc_t p_q [NN];
  apsp_pkg::acc_t p_d [NN];
  apsp_pkg::acc_t td_q [NN];
  apsp_pkg::acc_t td_d [NN];
  logic [NN-1:0] pok_q, pok_d, tok_q, tok_d, vis_q, vis_d;
  logic [NN*NN-1:0] wr_q, wr_d;
  logic ov_q, ov_d, orc_q, orc_d;
  apsp_pkg::status_e ost_q, ost_d;
  apsp_pkg::dist_t odist_q, odist_d;

  // memory ports
  logic e_we;
  logic [apsp_pkg::EdgeAW-1:0] e_waddr;
  apsp_pkg::edge_t e_wdata, e_rdata;
  logic rw_we;
  logic [PW-1:0] rw_waddr, rw_raddr;
  apsp_pkg::acc_t rw_wdata, rw_rdata;
  logic d_we;
  logic [PW-1:0] d_waddr, d_raddr;
  logic [apsp_pkg::DistW:0] d_wdata, d_rdata;

  logic acc;
  logic [NW-1:0] p_ra;
  apsp_pkg::acc_t p_rd, td_rd, sum_xw, nd, wv, fin;
  logic pok_rd, tok_rd, better, pres;
  logic [apsp_pkg::CntW-1:0] n5;

  apsp_ram #(.WIDTH($bits(apsp_pkg::edge_t)), .DEPTH(apsp_pkg::MaxEdges)) u_edge_ram (
    .clk_i(clk_i), .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_q), .rdata_o(e_rdata)
  );

  apsp_ram #(.WIDTH(apsp_pkg::AccW), .DEPTH(NN * NN)) u_rw_ram (
    .clk_i(clk_i), .we_i(rw_we), .waddr_i(rw_waddr), .wdata_i(rw_wdata),
    .raddr_i(rw_raddr), .rdata_o(rw_rdata)
  );

  apsp_ram #(.WIDTH(apsp_pkg::DistW + 1), .DEPTH(NN * NN)) u_dist_ram (
    .clk_i(clk_i), .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  assign in_stall_o  = (state_q != apsp_pkg::S_IDLE) || ov_q;
  assign acc         = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign status_o    = ost_q;
  assign reachable_o = orc_q;
  assign distance_o  = odist_q;

  assign n5 = {1'b0, nm1_q} + apsp_pkg::CntW'(1);

  // single read port into the potentials (S_BF_VIRT reads them all directly)
  always_comb begin
    unique case (state_q)
      apsp_pkg::S_E_X:     p_ra = e_rdata.tail;
      apsp_pkg::S_E_Y:     p_ra = y_q;
      apsp_pkg::S_DJ_INIT: p_ra = k_q;
      default:             p_ra = j_q;
    endcase
  end

  assign p_rd   = p_q[p_ra];
  assign pok_rd = pok_q[p_ra];
  assign td_rd  = td_q[j_q];
  assign tok_rd = tok_q[j_q];
  assign sum_xw = px_q + apsp_pkg::acc_t'(w_q);
  assign wv     = wr_q[{x_q, j_q}] ? rw_rdata : '0;
  assign pres   = wr_q[{x_q, j_q}] || (x_q == j_q);
  assign nd     = bx_q + wv;
  assign fin    = td_rd - pk_q + p_rd;
  assign better = !vis_q[j_q] &&
                  (!found_q || (tok_rd && (!bok_q || td_rd < bx_q)));

  assign rw_raddr = {x_q, j_q};
  assign d_raddr  = {from_node_i, to_node_i};

  always_comb begin
    state_d = state_q;  phase_d = phase_q;  res_d = res_q;
    nodes_d = nodes_q;  nm1_d = nm1_q;      ecnt_d = ecnt_q;
    e_d = e_q;  pass_d = pass_q;  x_d = x_q;  y_d = y_q;  k_d = k_q;
    j_d = j_q;  it_d = it_q;  w_d = w_q;  px_d = px_q;  bx_d = bx_q;
    pk_d = pk_q;  okx_d = okx_q;  inr_d = inr_q;  found_d = found_q;
    bok_d = bok_q;  p_d = p_q;  td_d = td_q;  pok_d = pok_q;
    tok_d = tok_q;  vis_d = vis_q;  wr_d = wr_q;
    ov_d = ov_q && out_stall_i;
    ost_d = ost_q;  orc_d = orc_q;  odist_d = odist_q;
    e_we = 1'b0;  e_waddr = ecnt_q[apsp_pkg::EdgeAW-1:0];
    e_wdata = '{tail: from_node_i, head: to_node_i, cost: edge_cost_i};
    rw_we = 1'b0;  rw_waddr = {x_q, y_q};
    rw_wdata = apsp_pkg::acc_t'(w_q) + px_q - p_rd;
    d_we = 1'b0;  d_waddr = {k_q, j_q};
    d_wdata = {tok_rd, tok_rd ? apsp_pkg::sat_dist(fin) : apsp_pkg::dist_t'(0)};

    unique case (state_q)
      apsp_pkg::S_IDLE: begin
        if (acc) begin
          ost_d = apsp_pkg::ST_OK;  orc_d = 1'b0;  odist_d = '0;
          unique case (apsp_pkg::cmd_e'(command_i))
            apsp_pkg::CMD_CLEAR: begin
              ecnt_d = '0;  res_d = apsp_pkg::ST_NONE;  ov_d = 1'b1;
            end
            apsp_pkg::CMD_LOAD: begin
              ov_d = 1'b1;
              if (ecnt_q == apsp_pkg::EcntW'(apsp_pkg::MaxEdges)) begin
                ost_d = apsp_pkg::ST_FULL;
              end else begin
                e_we = 1'b1;
                ecnt_d = ecnt_q + apsp_pkg::EcntW'(1);
                res_d = apsp_pkg::ST_NONE;
              end
            end
            apsp_pkg::CMD_COMPUTE: begin
              if (nodes_q == '0) begin
                nm1_d = '0;
              end else if (nodes_q > apsp_pkg::CntW'(NN)) begin
                nm1_d = NW'(NN - 1);
              end else begin
                nm1_d = NW'(nodes_q - apsp_pkg::CntW'(1));
              end
              pok_d = '0;  pass_d = '0;  phase_d = apsp_pkg::PH_BF;
              state_d = apsp_pkg::S_E_START;
            end
            apsp_pkg::CMD_READ: begin
              if (res_q != apsp_pkg::ST_OK) begin
                ost_d = res_q;  ov_d = 1'b1;
              end else if (from_node_i <= nm1_q && to_node_i <= nm1_q) begin
                state_d = apsp_pkg::S_READ;
              end else begin
                ov_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      apsp_pkg::S_READ: begin
        ov_d = 1'b1;
        orc_d = d_rdata[apsp_pkg::DistW];
        odist_d = d_rdata[apsp_pkg::DistW-1:0];
        state_d = apsp_pkg::S_IDLE;
      end
      apsp_pkg::S_E_START: begin
        e_d = '0;
        state_d = (ecnt_q == '0) ? apsp_pkg::S_E_END : apsp_pkg::S_E_RD;
      end
      apsp_pkg::S_E_RD: state_d = apsp_pkg::S_E_X;
      apsp_pkg::S_E_X: begin
        x_d = e_rdata.tail;  y_d = e_rdata.head;  w_d = e_rdata.cost;
        px_d = p_rd;  okx_d = pok_rd;
        inr_d = (e_rdata.tail <= nm1_q) && (e_rdata.head <= nm1_q);
        state_d = apsp_pkg::S_E_Y;
      end
      apsp_pkg::S_E_Y: begin
        state_d = ({1'b0, e_q} + apsp_pkg::EcntW'(1) == ecnt_q) ?
                  apsp_pkg::S_E_END : apsp_pkg::S_E_RD;
        e_d = e_q + apsp_pkg::EdgeAW'(1);
        unique case (phase_q)
          apsp_pkg::PH_BF: begin
            if (inr_q && okx_q && (!pok_rd || p_rd > sum_xw)) begin
              p_d[y_q] = sum_xw;  pok_d[y_q] = 1'b1;
            end
          end
          apsp_pkg::PH_NC: begin
            if (inr_q && okx_q && (!pok_rd || p_rd > sum_xw)) begin
              res_d = apsp_pkg::ST_NEGCYC;
              ost_d = apsp_pkg::ST_NEGCYC;  orc_d = 1'b0;  odist_d = '0;
              ov_d = 1'b1;
              state_d = apsp_pkg::S_IDLE;
            end
          end
          default: begin
            if (inr_q) begin
              rw_we = 1'b1;  wr_d[{x_q, y_q}] = 1'b1;
            end
          end
        endcase
      end
      apsp_pkg::S_E_END: begin
        unique case (phase_q)
          apsp_pkg::PH_BF: state_d = apsp_pkg::S_BF_VIRT;
          apsp_pkg::PH_NC: begin
            wr_d = '0;  phase_d = apsp_pkg::PH_RW;  state_d = apsp_pkg::S_E_START;
          end
          default: begin
            k_d = '0;  state_d = apsp_pkg::S_DJ_INIT;
          end
        endcase
      end
      apsp_pkg::S_BF_VIRT: begin
        // zero-cost edges from the virtual source
        for (int i = 0; i < NN; i++) begin
          if (NW'(i) <= nm1_q && (!pok_q[i] || p_q[i] > apsp_pkg::acc_t'(0))) begin
            p_d[i] = '0;  pok_d[i] = 1'b1;
          end
        end
        if (pass_q == n5) begin
          phase_d = apsp_pkg::PH_NC;
        end else begin
          pass_d = pass_q + apsp_pkg::CntW'(1);
        end
        state_d = apsp_pkg::S_E_START;
      end
      apsp_pkg::S_DJ_INIT: begin
        tok_d = '0;  vis_d = '0;
        td_d[k_q] = '0;  tok_d[k_q] = 1'b1;
        pk_d = p_rd;  it_d = '0;  j_d = '0;  found_d = 1'b0;
        state_d = apsp_pkg::S_DJ_SCAN;
      end
      apsp_pkg::S_DJ_SCAN: begin
        if (better) begin
          x_d = j_q;  found_d = 1'b1;  bx_d = td_rd;  bok_d = tok_rd;
        end
        j_d = j_q + NW'(1);
        if (j_q == nm1_q) begin
          state_d = apsp_pkg::S_DJ_PICK;
        end
      end
      apsp_pkg::S_DJ_PICK: begin
        j_d = '0;
        if (!found_q || !bok_q) begin
          state_d = apsp_pkg::S_DJ_STORE;
        end else begin
          vis_d[x_q] = 1'b1;
          state_d = apsp_pkg::S_DJ_RRD;
        end
      end
      apsp_pkg::S_DJ_RRD: state_d = apsp_pkg::S_DJ_RLX;
      apsp_pkg::S_DJ_RLX: begin
        if (pres && (!tok_rd || td_rd > nd)) begin
          td_d[j_q] = nd;  tok_d[j_q] = 1'b1;
        end
        j_d = j_q + NW'(1);
        state_d = apsp_pkg::S_DJ_RRD;
        if (j_q == nm1_q) begin
          j_d = '0;  found_d = 1'b0;  it_d = it_q + NW'(1);
          state_d = (it_q == nm1_q) ? apsp_pkg::S_DJ_STORE : apsp_pkg::S_DJ_SCAN;
        end
      end
      apsp_pkg::S_DJ_STORE: begin
        d_we = 1'b1;
        j_d = j_q + NW'(1);
        if (j_q == nm1_q) begin
          if (k_q == nm1_q) begin
            res_d = apsp_pkg::ST_OK;
            ost_d = apsp_pkg::ST_OK;  orc_d = 1'b0;  odist_d = '0;
            ov_d = 1'b1;
            state_d = apsp_pkg::S_IDLE;
          end else begin
            k_d = k_q + NW'(1);
            state_d = apsp_pkg::S_DJ_INIT;
          end
        end
      end
      default: state_d = apsp_pkg::S_IDLE;
    endcase

    if (cfg_valid_i) begin
      nodes_d = cfg_data_i;
      res_d = apsp_pkg::ST_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apsp_pkg::S_IDLE;
      phase_q <= apsp_pkg::PH_BF;
      res_q   <= apsp_pkg::ST_NONE;
      nodes_q <= apsp_pkg::CntW'(NN);
      nm1_q   <= '0;
      ecnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      res_q   <= res_d;
      nodes_q <= nodes_d;
      nm1_q   <= nm1_d;
      ecnt_q  <= ecnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d;  pass_q <= pass_d;  x_q <= x_d;  y_q <= y_d;  k_q <= k_d;
    j_q <= j_d;  it_q <= it_d;  w_q <= w_d;  px_q <= px_d;  bx_q <= bx_d;
    pk_q <= pk_d;  okx_q <= okx_d;  inr_q <= inr_d;  found_q <= found_d;
    bok_q <= bok_d;  p_q <= p_d;  td_q <= td_d;  pok_q <= pok_d;
    tok_q <= tok_d;  vis_q <= vis_d;  wr_q <= wr_d;
    ost_q <= ost_d;  orc_q <= orc_d;  odist_q <= odist_d;
  end

`ifndef SYNTHESIS
  a_read_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && command_i == apsp_pkg::CMD_READ && res_q != apsp_pkg::ST_OK && !cfg_valid_i)
    |=> (out_valid_o && status_o == $past(res_q)))
    else $error("read before a valid compute did not report result state");
  a_reach_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reachable_o) |-> (status_o == apsp_pkg::ST_OK))
    else $error("reachable set on a non-ok transaction");
  a_edge_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == apsp_pkg::S_E_RD) |-> ({1'b0, e_q} < ecnt_q))
    else $error("edge walk beyond stored edges");
`endif

endmodule
